@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/hpt_pkg.sv @@
// Shared types and constants of the homogeneous point transform.
`timescale 1ns / 1ps

package hpt_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int COMP_W            = 32;
	localparam int MAT_DIM           = 4;
	localparam int N_COEF            = MAT_DIM * MAT_DIM;
	localparam int COEF_IDX_W        = $clog2(N_COEF);

	localparam int S_TDATA_W = ((COEF_IDX_W + (MAT_DIM + 1) * COMP_W + 7) / 8) * 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = MAT_DIM * COMP_W;
	localparam int M_TUSER_W = 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
	localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W - 1){1'b0}}};

	// Input word kinds as they arrive on tuser.
	typedef enum logic [S_TUSER_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_AFFINE = 2'd2
	} kind_e;

	// Operations held in the queue between front and back.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_FULL,
		OP_AFFINE
	} op_e;

	typedef struct packed {
		op_e                             op;
		logic [COEF_IDX_W-1:0]           coef_index;
		logic [COMP_W-1:0]               coef_value;
		logic [MAT_DIM-1:0][COMP_W-1:0]  pt;
	} queue_word_t;

endpackage

@@ rtl/hpt_queue.sv @@
// Small first-in first-out queue between the front and the back.
`timescale 1ns / 1ps

module hpt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  hpt_pkg::queue_word_t push_word,
	output logic                 pop_valid,
	input  logic                 pop,
	output hpt_pkg::queue_word_t pop_word
);

	hpt_pkg::queue_word_t              mem_q [hpt_pkg::QUEUE_DEPTH];
	logic [hpt_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [hpt_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [hpt_pkg::QCNT_W-1:0]        cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (cnt_q != hpt_pkg::QCNT_W'(hpt_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store the pushed word.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/hpt_front.sv @@
// Front end: unpacks incoming words and classifies them into queue operations.
`timescale 1ns / 1ps

module hpt_front (
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [hpt_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	input  logic [hpt_pkg::S_TUSER_W-1:0]       s_axis_tuser,
	input  logic                                push_ready,
	output logic                                push_valid,
	output hpt_pkg::queue_word_t                push_word
);

	localparam int VAL_LO = hpt_pkg::COEF_IDX_W;
	localparam int PT_LO  = VAL_LO + hpt_pkg::COMP_W;

	logic keep;

	// Accept whenever the queue has room; unused kinds are taken and dropped.
	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid && keep;

	// Unpack the payload fields and decode the kind.
	always_comb begin
		push_word.coef_index = s_axis_tdata[hpt_pkg::COEF_IDX_W-1:0];
		push_word.coef_value = s_axis_tdata[VAL_LO +: hpt_pkg::COMP_W];
		for (int c = 0; c < hpt_pkg::MAT_DIM; c++) begin
			push_word.pt[c] = s_axis_tdata[PT_LO + c * hpt_pkg::COMP_W +: hpt_pkg::COMP_W];
		end
		unique case (hpt_pkg::kind_e'(s_axis_tuser))
			hpt_pkg::KIND_LOAD: begin
				push_word.op = hpt_pkg::OP_LOAD;
				keep         = 1'b1;
			end
			hpt_pkg::KIND_FULL: begin
				push_word.op = hpt_pkg::OP_FULL;
				keep         = 1'b1;
			end
			hpt_pkg::KIND_AFFINE: begin
				push_word.op = hpt_pkg::OP_AFFINE;
				keep         = 1'b1;
			end
			default: begin
				push_word.op = hpt_pkg::OP_LOAD;
				keep         = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/hpt_back.sv @@
// Back end: coefficient registers and the multiply, sum and saturate pipeline.
`timescale 1ns / 1ps

module hpt_back #(
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  hpt_pkg::queue_word_t              q_word,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [hpt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	output logic [hpt_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

	localparam int CW = hpt_pkg::COMP_W;
	localparam int MD = hpt_pkg::MAT_DIM;
	localparam int PW = 2 * CW - FRAC_BITS;
	localparam int HW = PW + 1;
	localparam int SW = PW + 2;
	localparam logic [CW-1:0] COEF_ONE = {{(CW - 1){1'b0}}, 1'b1} << FRAC_BITS;

	logic [CW-1:0]            coef_q [hpt_pkg::N_COEF];

	logic signed [2*CW-1:0]   mul_full [MD][MD];
	logic signed [PW-1:0]     term     [MD][MD];

	logic                     v_s1, v_s2, v_s3;
	logic                     affine_s1, affine_s2, affine_s3;
	logic [CW-1:0]            w_s1, w_s2, w_s3;
	logic signed [PW-1:0]     prod_s1 [MD][MD];
	logic signed [HW-1:0]     pair_s2 [MD][2];
	logic signed [SW-1:0]     sum_s3  [MD];

	logic                     out_valid_q;
	logic [hpt_pkg::M_TDATA_W-1:0] out_data_q;
	logic                     out_sat_q;

	logic [MD-1:0][CW-1:0]    clip;
	logic [MD-1:0]            ovf;
	logic                     adv;
	logic                     is_load;
	logic                     start;

	// Advance the pipeline while the output register is free or being taken.
	assign adv     = !out_valid_q || m_axis_tready;
	assign is_load = (q_word.op == hpt_pkg::OP_LOAD);
	assign q_pop   = q_valid && (is_load || adv);
	assign start   = q_valid && !is_load && adv;

	// Write coefficients in queue order; reset to identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hpt_pkg::N_COEF; k++) begin
				coef_q[k] <= (k / MD == k % MD) ? COEF_ONE : '0;
			end
		end else if (q_pop && is_load) begin
			coef_q[q_word.coef_index] <= q_word.coef_value;
		end
	end

	// Form the sixteen floored products; affine takes the translation column as is.
	always_comb begin
		for (int r = 0; r < MD; r++) begin
			for (int c = 0; c < MD; c++) begin
				mul_full[r][c] = $signed(coef_q[c * MD + r]) * $signed(q_word.pt[c]);
				if ((q_word.op == hpt_pkg::OP_AFFINE) && (c == MD - 1)) begin
					term[r][c] = {{(PW - CW){coef_q[c * MD + r][CW-1]}},
						coef_q[c * MD + r]};
				end else begin
					term[r][c] = mul_full[r][c][2*CW-1:FRAC_BITS];
				end
			end
		end
	end

	// Hold stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= start;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Advance the data path: products, pair sums, row sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			affine_s1 <= (q_word.op == hpt_pkg::OP_AFFINE);
			w_s1      <= q_word.pt[MD-1];
			affine_s2 <= affine_s1;
			w_s2      <= w_s1;
			affine_s3 <= affine_s2;
			w_s3      <= w_s2;
			for (int r = 0; r < MD; r++) begin
				for (int c = 0; c < MD; c++) begin
					prod_s1[r][c] <= term[r][c];
				end
				pair_s2[r][0] <= HW'(prod_s1[r][0]) + HW'(prod_s1[r][1]);
				pair_s2[r][1] <= HW'(prod_s1[r][2]) + HW'(prod_s1[r][3]);
				sum_s3[r]     <= SW'(pair_s2[r][0]) + SW'(pair_s2[r][1]);
			end
		end
	end

	// Saturate each row to the component range; affine mode passes w through unsaturated.
	always_comb begin
		for (int r = 0; r < MD; r++) begin
			ovf[r]  = !((&sum_s3[r][SW-1:CW-1]) || !(|sum_s3[r][SW-1:CW-1]));
			clip[r] = ovf[r] ? (sum_s3[r][SW-1] ? hpt_pkg::COMP_MIN : hpt_pkg::COMP_MAX)
				: sum_s3[r][CW-1:0];
		end
		if (affine_s3) begin
			clip[MD-1] = w_s3;
			ovf[MD-1]  = 1'b0;
		end
	end

	// Load the output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= clip;
			out_sat_q  <= |ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule

@@ rtl/homogeneous_point_transform.sv @@
// Top level of the homogeneous point transform.
//
//   channel   dir   carries
//   s_axis    in    load / full / affine word, kind on tuser
//   m_axis    out   transformed point, saturation flag on tuser
//
// One word per cycle sustained while the queue has room. A transform result
// passes, when the output is free, through the queue, the product stage of
// sixteen 32x32 multipliers, the pair-sum stage, the row-sum stage and the
// saturating output register. A load takes a queue slot and a pop, no result.
// Reset loads the identity matrix and empties the queue. A stalled output
// freezes the pipeline; the queue keeps taking words until it is full.
`timescale 1ns / 1ps

module homogeneous_point_transform #(
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// coef_index, coef_value, in_x, in_y, in_z, in_w, zero pad
	input  logic [hpt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// kind
	input  logic [hpt_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x, out_y, out_z, out_w
	output logic [hpt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// saturated
	output logic [hpt_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

	logic                 push_valid;
	logic                 push_ready;
	hpt_pkg::queue_word_t push_word;
	logic                 pop_valid;
	logic                 pop;
	hpt_pkg::queue_word_t pop_word;

	hpt_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_ready    (push_ready),
		.push_valid    (push_valid),
		.push_word     (push_word)
	);

	hpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_word   (pop_word)
	);

	hpt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (pop_valid),
		.q_pop         (pop),
		.q_word        (pop_word),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ rtl/hpt_checker.sv @@
// Port-level checker for the homogeneous point transform, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [hpt_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [hpt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input logic [hpt_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

	localparam int CW = hpt_pkg::COMP_W;

	logic [3:0] pending_q;
	logic       in_xform;
	logic       out_word;
	logic       clip_seen;

	assign in_xform = s_axis_tvalid && s_axis_tready &&
		((s_axis_tuser == hpt_pkg::KIND_FULL) || (s_axis_tuser == hpt_pkg::KIND_AFFINE));
	assign out_word = m_axis_tvalid && m_axis_tready;

	// Count transform words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'b000, in_xform} - {3'b000, out_word};
		end
	end

	// Flag a component sitting at either end of the range.
	assign clip_seen =
		(m_axis_tdata[0*CW +: CW] == hpt_pkg::COMP_MAX) ||
		(m_axis_tdata[0*CW +: CW] == hpt_pkg::COMP_MIN) ||
		(m_axis_tdata[1*CW +: CW] == hpt_pkg::COMP_MAX) ||
		(m_axis_tdata[1*CW +: CW] == hpt_pkg::COMP_MIN) ||
		(m_axis_tdata[2*CW +: CW] == hpt_pkg::COMP_MAX) ||
		(m_axis_tdata[2*CW +: CW] == hpt_pkg::COMP_MIN) ||
		(m_axis_tdata[3*CW +: CW] == hpt_pkg::COMP_MAX) ||
		(m_axis_tdata[3*CW +: CW] == hpt_pkg::COMP_MIN);

	`HPT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`HPT_ASSERT_IMPL(a_no_spurious_word, clk, arst_n, m_axis_tvalid, pending_q != 4'd0)

	`HPT_ASSERT_IMPL(a_sat_clipped, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], clip_seen)

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

@@ tb/homogeneous_point_transform_test.sv @@
// Stream testbench for the homogeneous point transform, checked against a predictor.
`timescale 1ns / 1ps

module homogeneous_point_transform_test;

	localparam int FRAC = hpt_pkg::FRAC_BITS_DEFAULT;
	localparam logic [hpt_pkg::S_TUSER_W-1:0] KIND_UNUSED = 2'd3;

	// One input word, fields as the block sees them
	typedef struct packed {
		logic [hpt_pkg::S_TUSER_W-1:0]  kind;
		logic [hpt_pkg::COEF_IDX_W-1:0] coef_index;
		logic signed [31:0]             coef_value;
		logic signed [31:0]             x;
		logic signed [31:0]             y;
		logic signed [31:0]             z;
		logic signed [31:0]             w;
	} vertex_word_t;

	// One transformed point
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               sat;
	} point_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [hpt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [hpt_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [hpt_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [hpt_pkg::M_TUSER_W-1:0] m_axis_tuser;

	vertex_word_t  pending_words[$];
	point_result_t expected_points[$];
	vertex_word_t  word_on_bus;
	logic signed [31:0] matrix_coef [hpt_pkg::N_COEF];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;

	homogeneous_point_transform uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock and a single reset pulse
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// Fixed-point product, floor of a*b / 2^FRAC
	function automatic logic signed [63:0] scaled_product(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		wa = 64'(a);
		wb = 64'(b);
		return (wa * wb) >>> FRAC;
	endfunction

	// Multiply a point by the column-major matrix, saturating each row; affine passes w through
	function automatic point_result_t apply_matrix(vertex_word_t v);
		logic signed [31:0] pt [4];
		logic signed [31:0] comp [4];
		logic signed [63:0] acc;
		logic signed [63:0] shift_in;
		point_result_t res;
		pt[0] = v.x;
		pt[1] = v.y;
		pt[2] = v.z;
		pt[3] = v.w;
		res.sat = 1'b0;
		for (int r = 0; r < 4; r++) begin
			if (v.kind == hpt_pkg::KIND_AFFINE && r == 3) begin
				comp[3] = v.w;
			end else begin
				acc = '0;
				for (int c = 0; c < 3; c++)
					acc += scaled_product(matrix_coef[c * 4 + r], pt[c]);
				if (v.kind == hpt_pkg::KIND_FULL) begin
					acc += scaled_product(matrix_coef[12 + r], pt[3]);
				end else begin
					shift_in = 64'(matrix_coef[12 + r]);
					acc += shift_in;
				end
				if (acc > 64'sh7FFF_FFFF) begin
					comp[r] = hpt_pkg::COMP_MAX;
					res.sat = 1'b1;
				end else if (acc < -64'sh8000_0000) begin
					comp[r] = hpt_pkg::COMP_MIN;
					res.sat = 1'b1;
				end else begin
					comp[r] = acc[31:0];
				end
			end
		end
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		res.w = comp[3];
		return res;
	endfunction

	// Point component: extremes, full-range noise or moderate values
	function automatic logic [31:0] pick_component();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return hpt_pkg::COMP_MAX;
			1: return hpt_pkg::COMP_MIN;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			3, 4, 5: return r;
			default: return {{12{r[19]}}, r[19:0]};
		endcase
	endfunction

	// Coefficient: mostly within a few units so sums stay in range
	function automatic logic [31:0] pick_coef();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return 32'h0001_0000;
			1: return $urandom_range(1) ? hpt_pkg::COMP_MAX : hpt_pkg::COMP_MIN;
			2, 3: return r;
			default: return {{14{r[17]}}, r[17:0]};
		endcase
	endfunction

	function automatic void queue_point(logic [hpt_pkg::S_TUSER_W-1:0] kind, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] w);
		vertex_word_t v;
		v.kind = kind;
		v.coef_index = hpt_pkg::COEF_IDX_W'($urandom);
		v.coef_value = $urandom;
		v.x = x;
		v.y = y;
		v.z = z;
		v.w = w;
		pending_words.push_back(v);
	endfunction

	function automatic void queue_load(logic [hpt_pkg::COEF_IDX_W-1:0] idx,
			logic [31:0] value);
		queue_point(hpt_pkg::KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
		pending_words[$].coef_index = idx;
		pending_words[$].coef_value = value;
	endfunction

	// Hold until every word is taken and every point has come back
	task automatic wait_drained();
		while (pending_words.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int count, input int send_pct, input int recv_pct);
		int made;
		int roll;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				queue_point(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else begin
				made++;
				if (roll < 16)
					queue_load(hpt_pkg::COEF_IDX_W'($urandom_range(hpt_pkg::N_COEF - 1)),
						pick_coef());
				else
					queue_point(roll < 58 ? hpt_pkg::KIND_FULL : hpt_pkg::KIND_AFFINE,
						pick_component(), pick_component(), pick_component(),
						pick_component());
			end
		end
		wait_drained();
	endtask

	// Driver: present queued words, update the predictor on each accepted word
	always @(posedge clk) begin : drive_words
		vertex_word_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			// Identity matrix out of reset
			for (int i = 0; i < hpt_pkg::N_COEF; i++)
				matrix_coef[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (word_on_bus.kind == hpt_pkg::KIND_LOAD)
					matrix_coef[word_on_bus.coef_index] = word_on_bus.coef_value;
				else if (word_on_bus.kind == hpt_pkg::KIND_FULL ||
						word_on_bus.kind == hpt_pkg::KIND_AFFINE)
					expected_points.push_back(apply_matrix(word_on_bus));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_words.pop_front();
					word_on_bus = nxt;
					s_axis_tdata <= hpt_pkg::S_TDATA_W'({nxt.w, nxt.z, nxt.y, nxt.x,
						nxt.coef_value, nxt.coef_index});
					s_axis_tuser <= nxt.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted point with the oldest prediction
	always @(posedge clk) begin : check_points
		point_result_t want;
		point_result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[31:0];
				got.y = m_axis_tdata[63:32];
				got.z = m_axis_tdata[95:64];
				got.w = m_axis_tdata[127:96];
				got.sat = m_axis_tuser[0];
				if (expected_points.size() == 0) begin
					$error("point word with none expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x) begin
						$error("out_x: expected %h, got %h", want.x, got.x);
						fail_count++;
					end
					if (got.y !== want.y) begin
						$error("out_y: expected %h, got %h", want.y, got.y);
						fail_count++;
					end
					if (got.z !== want.z) begin
						$error("out_z: expected %h, got %h", want.z, got.z);
						fail_count++;
					end
					if (got.w !== want.w) begin
						$error("out_w: expected %h, got %h", want.w, got.w);
						fail_count++;
					end
					if (got.sat !== want.sat) begin
						$error("saturated: expected %b, got %b", want.sat, got.sat);
						fail_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus
	initial begin
		@(posedge arst_n);
		@(negedge clk);

		// Identity passes extremes through untouched
		queue_point(hpt_pkg::KIND_FULL, hpt_pkg::COMP_MAX, hpt_pkg::COMP_MIN, 32'h0,
			32'h0001_0000);
		queue_point(hpt_pkg::KIND_FULL, 32'hFFFF_FFFF, 32'h0, hpt_pkg::COMP_MIN,
			hpt_pkg::COMP_MAX);
		queue_point(hpt_pkg::KIND_AFFINE, 32'h0003_8000, 32'hFFFE_0000, 32'h1,
			32'h1234_5678);
		// Unused kind: no state change, no result
		queue_point(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
		// Translation drives x up and y down into saturation
		queue_load(4'd12, hpt_pkg::COMP_MAX);
		queue_point(hpt_pkg::KIND_AFFINE, hpt_pkg::COMP_MAX, 32'h0, 32'h0, hpt_pkg::COMP_MIN);
		queue_load(4'd13, hpt_pkg::COMP_MIN);
		queue_point(hpt_pkg::KIND_AFFINE, 32'h0, hpt_pkg::COMP_MIN, 32'h0, 32'h0);
		// Full mode with w of zero drops the translation
		queue_point(hpt_pkg::KIND_FULL, hpt_pkg::COMP_MAX, hpt_pkg::COMP_MIN,
			hpt_pkg::COMP_MAX, 32'h0);
		queue_point(hpt_pkg::KIND_FULL, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
		// Most negative times most negative
		queue_load(4'd0, hpt_pkg::COMP_MIN);
		queue_point(hpt_pkg::KIND_FULL, hpt_pkg::COMP_MIN, 32'h0, 32'h0, 32'h0);
		queue_point(hpt_pkg::KIND_FULL, hpt_pkg::COMP_MAX, 32'h0, 32'h0, 32'h0);
		// Negative products round toward minus infinity
		queue_load(4'd0, 32'hFFFF_FFFF);
		queue_point(hpt_pkg::KIND_FULL, 32'h1, 32'h0, 32'h0, 32'h0);
		queue_point(hpt_pkg::KIND_FULL, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
		queue_point(hpt_pkg::KIND_AFFINE, 32'h3, 32'h0, 32'h0, 32'h0);
		// Projection row saturates in full mode only
		queue_load(4'd15, hpt_pkg::COMP_MIN);
		queue_point(hpt_pkg::KIND_FULL, 32'h0, 32'h0, 32'h0, hpt_pkg::COMP_MIN);
		queue_point(hpt_pkg::KIND_AFFINE, 32'h0, 32'h0, 32'h0, hpt_pkg::COMP_MIN);
		queue_load(4'd7, hpt_pkg::COMP_MAX);
		queue_point(hpt_pkg::KIND_FULL, hpt_pkg::COMP_MAX, hpt_pkg::COMP_MAX,
			hpt_pkg::COMP_MAX, hpt_pkg::COMP_MAX);
		wait_drained();

		run_phase(214, 0, 0);
		run_phase(214, 71, 0);
		run_phase(214, 0, 71);
		run_phase(214, 14, 14);

		// Let any stray word show up before the verdict
		repeat (20) @(negedge clk);
		if (fail_count == 0 && expected_points.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
